/* src/complex_arithmetic_unit_assert.svh */
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define CAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* src/cau_pkg.sv */
// types, constants and helper functions of the complex arithmetic unit
package cau_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int EW           = (WORD_BITS < 32) ? WORD_BITS : 32;

    localparam int DIV_STEPS    = 64 + FRAC_BITS;
    localparam int SQRT_STEPS   = 32;
    localparam int SQ_TOP       = 62;
    localparam int N_CELLS      = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
    localparam int STEP_W       = $clog2(N_CELLS);
    localparam int CW           = 36;

    localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_MOD  = 3'd5,
        OP_ARG  = 3'd6,
        OP_EQ   = 3'd7
    } t_op;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    typedef struct packed {
        t_op                  op;
        logic                 err;
        logic                 eq;
        logic                 sat;
        logic [31:0]          re;
        logic [31:0]          im;
        logic                 neg1;
        logic                 neg2;
        logic [63:0]          num1;
        logic [63:0]          num2;
        logic [63:0]          rem1;
        logic [63:0]          rem2;
        logic [63:0]          den;
        logic [32:0]          q1;
        logic [32:0]          q2;
        logic                 st1;
        logic                 st2;
        logic [63:0]          sq_s;
        logic [63:0]          sq_res;
        logic                 run;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
    } t_cell;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        err;
        logic        eq;
        logic        sat;
    } t_rsp;

    // operand is the low EW bits, sign-extended
    function automatic logic signed [31:0] sext_in(input logic [31:0] v);
        return $signed(v << (32 - EW)) >>> (32 - EW);
    endfunction

    function automatic logic [65:0] abs66(input logic signed [65:0] v);
        return v[65] ? 66'(-v) : 66'(v);
    endfunction

    function automatic t_sat sat_sm(input logic neg, input logic [65:0] mag);
        t_sat        r;
        logic [65:0] lim;
        lim   = 66'(1) << (EW - 1);
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > lim - 66'(1)) begin
                r.sat = 1'b1;
                r.val = 32'(lim - 66'(1));
            end else begin
                r.val = 32'(mag);
            end
        end else begin
            if (mag > lim) begin
                r.sat = 1'b1;
                r.val = 32'(66'(0) - lim);
            end else begin
                r.val = 32'(66'(0) - mag);
            end
        end
        return r;
    endfunction

    function automatic t_sat sat_v(input logic signed [65:0] v);
        return sat_sm(v[65], abs66(v));
    endfunction

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd7;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return $signed(CW'(v));
    endfunction

endpackage

/* src/cau_if.sv */
// request and response channel interfaces of the complex arithmetic unit
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_re;
    logic signed [31:0] r_im;
    logic               error;
    logic               equal;
    logic               saturated;

    modport source (output valid, r_re, r_im, error, equal, saturated, input ready);
    modport sink (input valid, r_re, r_im, error, equal, saturated, output ready);
endinterface

/* src/cau_front.sv */
// front end: operand products, then per-opcode setup of the cell chain
module cau_front import cau_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_op                i_op,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_valid,
    output t_cell              o_data
);

    logic signed [31:0] ar, ai, br, bi, mb_re, mb_im;
    logic signed [63:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir, n_p_bbr, n_p_bbi;

    logic               r_v1;
    t_op                r_op1;
    logic signed [31:0] r_ar, r_ai, r_br, r_bi;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bbr, r_p_bbi;

    logic signed [65:0] s_mr, s_mi, s_dr, s_di;
    logic [63:0]        den;
    t_sat               sr, si;
    t_cell              n_d2;
    logic               r_v2;
    t_cell              r_d2;

    assign ar = sext_in(i_a_re);
    assign ai = sext_in(i_a_im);
    assign br = sext_in(i_b_re);
    assign bi = sext_in(i_b_im);

    // modulus squares a, so the first two multipliers take a as their second input
    assign mb_re = (i_op == OP_MOD) ? ar : br;
    assign mb_im = (i_op == OP_MOD) ? ai : bi;

    assign n_p_rr  = ar * mb_re;
    assign n_p_ii  = ai * mb_im;
    assign n_p_ri  = ar * bi;
    assign n_p_ir  = ai * br;
    assign n_p_bbr = br * br;
    assign n_p_bbi = bi * bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op1   <= i_op;
            r_ar    <= ar;
            r_ai    <= ai;
            r_br    <= br;
            r_bi    <= bi;
            r_p_rr  <= n_p_rr;
            r_p_ii  <= n_p_ii;
            r_p_ri  <= n_p_ri;
            r_p_ir  <= n_p_ir;
            r_p_bbr <= n_p_bbr;
            r_p_bbi <= n_p_bbi;
        end
    end

    assign s_mr = 66'(r_p_rr) - 66'(r_p_ii);
    assign s_mi = 66'(r_p_ri) + 66'(r_p_ir);
    assign s_dr = 66'(r_p_rr) + 66'(r_p_ii);
    assign s_di = 66'(r_p_ir) - 66'(r_p_ri);
    assign den  = $unsigned(r_p_bbr) + $unsigned(r_p_bbi);

    always_comb begin
        n_d2    = '0;
        n_d2.op = r_op1;
        sr      = '0;
        si      = '0;
        case (r_op1)
            OP_ADD: begin
                sr        = sat_v(66'(r_ar) + 66'(r_br));
                si        = sat_v(66'(r_ai) + 66'(r_bi));
                n_d2.re   = sr.val;
                n_d2.im   = si.val;
                n_d2.sat  = sr.sat | si.sat;
            end
            OP_SUB: begin
                sr        = sat_v(66'(r_ar) - 66'(r_br));
                si        = sat_v(66'(r_ai) - 66'(r_bi));
                n_d2.re   = sr.val;
                n_d2.im   = si.val;
                n_d2.sat  = sr.sat | si.sat;
            end
            OP_MUL: begin
                sr        = sat_sm(s_mr[65], abs66(s_mr) >> FRAC_BITS);
                si        = sat_sm(s_mi[65], abs66(s_mi) >> FRAC_BITS);
                n_d2.re   = sr.val;
                n_d2.im   = si.val;
                n_d2.sat  = sr.sat | si.sat;
            end
            OP_DIV: begin
                n_d2.err  = (den == '0);
                n_d2.neg1 = s_dr[65];
                n_d2.neg2 = s_di[65];
                n_d2.num1 = 64'(abs66(s_dr));
                n_d2.num2 = 64'(abs66(s_di));
                n_d2.den  = den;
            end
            OP_CONJ: begin
                si        = sat_v(-66'(r_ai));
                n_d2.re   = r_ar;
                n_d2.im   = si.val;
                n_d2.sat  = si.sat;
            end
            OP_MOD: begin
                n_d2.sq_s = $unsigned(r_p_rr) + $unsigned(r_p_ii);
            end
            OP_ARG: begin
                n_d2.err = (r_ar == '0) && (r_ai == '0);
                // points on an axis get their angle here and skip the rotations
                if (r_ar == '0) begin
                    n_d2.cz = (r_ai > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
                end else if (r_ai == '0) begin
                    n_d2.cz = (r_ar > 0) ? '0 : PI_Q30;
                end else begin
                    n_d2.run = 1'b1;
                    if (r_ar < 0) begin
                        n_d2.cz = (r_ai > 0) ? PI_Q30 : -PI_Q30;
                        n_d2.cx = -CW'(r_ar);
                        n_d2.cy = -CW'(r_ai);
                    end else begin
                        n_d2.cx = CW'(r_ar);
                        n_d2.cy = CW'(r_ai);
                    end
                end
            end
            OP_EQ: begin
                n_d2.eq = (r_ar == r_br) && (r_ai == r_bi);
            end
            default: begin
                n_d2.eq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_d2;

endmodule

/* src/cau_cell.sv */
// one cell of the chain: a divider bit for both parts, a square-root digit, a cordic rotation
module cau_cell import cau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [STEP_W-1:0] i_step,
    input  logic              i_valid,
    input  t_cell             i_data,
    output logic              o_valid,
    output t_cell             o_data
);

    logic [63:0]          rs1, rs2, sq_bit, sq_try;
    logic [5:0]           sq_sh;
    logic                 ge1, ge2;
    logic signed [CW-1:0] dx, dy, atan_v;
    t_cell                n_data;
    logic                 r_valid;
    t_cell                r_data;

    assign rs1 = {i_data.rem1[62:0], i_data.num1[63]};
    assign rs2 = {i_data.rem2[62:0], i_data.num2[63]};
    assign ge1 = (rs1 >= i_data.den);
    assign ge2 = (rs2 >= i_data.den);
    assign dx  = i_data.cy >>> i_step;
    assign dy  = i_data.cx >>> i_step;
    assign atan_v = atan_q30(i_step[4:0]);

    always_comb begin
        n_data = i_data;
        sq_sh  = '0;
        sq_bit = '0;
        sq_try = '0;

        // restoring division; a quotient bit falling off the top marks overflow
        n_data.rem1 = ge1 ? rs1 - i_data.den : rs1;
        n_data.rem2 = ge2 ? rs2 - i_data.den : rs2;
        n_data.num1 = {i_data.num1[62:0], 1'b0};
        n_data.num2 = {i_data.num2[62:0], 1'b0};
        n_data.st1  = i_data.st1 | i_data.q1[32];
        n_data.st2  = i_data.st2 | i_data.q2[32];
        n_data.q1   = {i_data.q1[31:0], ge1};
        n_data.q2   = {i_data.q2[31:0], ge2};

        if (i_step < STEP_W'(SQRT_STEPS)) begin
            sq_sh  = 6'(SQ_TOP - 2 * int'(i_step));
            sq_bit = 64'(1) << sq_sh;
            sq_try = i_data.sq_res + sq_bit;
            if (i_data.sq_s >= sq_try) begin
                n_data.sq_s   = i_data.sq_s - sq_try;
                n_data.sq_res = (i_data.sq_res >> 1) + sq_bit;
            end else begin
                n_data.sq_res = i_data.sq_res >> 1;
            end
        end

        if (i_data.run && (i_step < STEP_W'(CORDIC_STEPS))) begin
            if (i_data.cy > 0) begin
                n_data.cx = i_data.cx + dx;
                n_data.cy = i_data.cy - dy;
                n_data.cz = i_data.cz + atan_v;
            end else begin
                n_data.cx = i_data.cx - dx;
                n_data.cy = i_data.cy + dy;
                n_data.cz = i_data.cz - atan_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/complex_arithmetic_unit.sv */
// Complex arithmetic unit on signed Q16.16 operands (add, sub, mul, div, conj, modulus,
// argument, compare). Takes one item per clock while ready is high and returns one result
// per item, in order. Every opcode takes the same path: two front stages (products, then
// setup), a chain of 80 cells set by the divider's 64 + 16 quotient bits (one bit per cell;
// the square root and the 16 cordic rotations ride the first cells), and the output register.
// A skid register behind the output lets the chain keep moving when the sink stalls, until
// it holds a result; ready drops only while that skid register is full.
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit import cau_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_req_if.sink    i_req,
    cau_rsp_if.source  o_rsp
);

    logic                en;
    logic                push;
    logic [N_CELLS:0]    c_valid;
    t_cell               c_data [0:N_CELLS];
    t_cell               last;
    t_sat                fr, fi;
    t_rsp                fin;
    logic                r_out_valid;
    logic                r_skid_valid;
    t_rsp                r_out;
    t_rsp                r_skid;
    logic                out_clean;

    assign en          = !r_skid_valid;
    assign i_req.ready = en;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_op    (t_op'(i_req.req_type)),
        .i_a_re  (i_req.a_re),
        .i_a_im  (i_req.a_im),
        .i_b_re  (i_req.b_re),
        .i_b_im  (i_req.b_im),
        .o_valid (c_valid[0]),
        .o_data  (c_data[0])
    );

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (STEP_W'(k)),
            .i_valid (c_valid[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    assign last = c_data[N_CELLS];

    always_comb begin
        fin = '0;
        fr  = '0;
        fi  = '0;
        case (last.op)
            OP_DIV: begin
                fin.err = last.err;
                if (!last.err) begin
                    fr      = sat_sm(last.neg1, last.st1 ? '1 : 66'(last.q1));
                    fi      = sat_sm(last.neg2, last.st2 ? '1 : 66'(last.q2));
                    fin.re  = fr.val;
                    fin.im  = fi.val;
                    fin.sat = fr.sat | fi.sat;
                end
            end
            OP_MOD: begin
                fr      = sat_sm(1'b0, 66'(last.sq_res));
                fin.re  = fr.val;
                fin.sat = fr.sat;
            end
            OP_ARG: begin
                fin.err = last.err;
                if (!last.err) begin
                    fr      = sat_v(66'(last.cz >>> (30 - FRAC_BITS)));
                    fin.re  = fr.val;
                    fin.sat = fr.sat;
                end
            end
            default: begin
                fin.re  = last.re;
                fin.im  = last.im;
                fin.err = last.err;
                fin.eq  = last.eq;
                fin.sat = last.sat;
            end
        endcase
    end

    assign push = en && c_valid[N_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_rsp.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !o_rsp.ready) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_rsp.ready) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !o_rsp.ready) begin
                r_skid <= fin;
            end else begin
                r_out <= fin;
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.r_re      = r_out.re;
    assign o_rsp.r_im      = r_out.im;
    assign o_rsp.error     = r_out.err;
    assign o_rsp.equal     = r_out.eq;
    assign o_rsp.saturated = r_out.sat;

    // zero result with no clipping
    assign out_clean = (r_out.re == '0) && (r_out.im == '0) && !r_out.sat;

    `CAU_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CAU_ASSERT_IMPL(a_err_gives_zero, i_clk, i_rst_n, r_out_valid && r_out.err, out_clean)
    `CAU_ASSERT_IMPL(a_eq_clean, i_clk, i_rst_n, r_out_valid && r_out.eq, out_clean && !r_out.err)
    `CAU_ASSERT_NEXT(a_chain_frozen, i_clk, i_rst_n, r_skid_valid && !o_rsp.ready, $stable(c_valid))

endmodule

/* verif/complex_arithmetic_unit_tb.sv */
// testbench of the complex arithmetic unit: directed, random and backpressure runs
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 120;

    typedef logic signed [127:0] t_wide;

    logic i_clk;
    logic i_rst_n;

    cau_req_if req_ch ();
    cau_rsp_if rsp_ch ();

    complex_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    t_rsp expected_rsp[$];
    int   fail_cnt   = 0;
    int   cycle_cnt  = 0;
    bit   send_idle  = 1'b0;
    bit   recv_idle  = 1'b0;
    int   hold_cnt   = 0;
    int   wait_cnt   = 0;
    bit   took_rsp   = 1'b0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // clip to the word, flag when clipped
    function automatic logic [31:0] clip_word(input t_wide v, inout logic sat);
        if (v > t_wide'(32'sh7fffffff)) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -t_wide'(64'sh80000000)) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_rsp cau_predict(input t_op op, input logic signed [31:0] ar,
                                         input logic signed [31:0] ai,
                                         input logic signed [31:0] br,
                                         input logic signed [31:0] bi);
        t_rsp        r;
        t_wide       wr, wi, xr, xi, s1, s2, den, q;
        logic        sat;
        logic [63:0] sq, root, bitv;
        longint      cx, cy, cz, dx, dy;
        r   = '0;
        sat = 1'b0;
        wr  = ar;
        wi  = ai;
        xr  = br;
        xi  = bi;
        case (op)
            OP_ADD: begin
                r.re = clip_word(wr + xr, sat);
                r.im = clip_word(wi + xi, sat);
            end
            OP_SUB: begin
                r.re = clip_word(wr - xr, sat);
                r.im = clip_word(wi - xi, sat);
            end
            OP_MUL: begin
                s1 = wr * xr - wi * xi;
                s2 = wr * xi + wi * xr;
                // magnitudes truncate toward zero
                s1 = (s1 < 0) ? -((-s1) >>> FRAC_BITS) : (s1 >>> FRAC_BITS);
                s2 = (s2 < 0) ? -((-s2) >>> FRAC_BITS) : (s2 >>> FRAC_BITS);
                r.re = clip_word(s1, sat);
                r.im = clip_word(s2, sat);
            end
            OP_DIV: begin
                den = xr * xr + xi * xi;
                if (den == 0) begin
                    r.err = 1'b1;
                end else begin
                    s1 = wr * xr + wi * xi;
                    s2 = wi * xr - wr * xi;
                    q  = ((s1 < 0 ? -s1 : s1) <<< FRAC_BITS) / den;
                    r.re = clip_word(s1 < 0 ? -q : q, sat);
                    q  = ((s2 < 0 ? -s2 : s2) <<< FRAC_BITS) / den;
                    r.im = clip_word(s2 < 0 ? -q : q, sat);
                end
            end
            OP_CONJ: begin
                r.re = ar;
                r.im = clip_word(-wi, sat);
            end
            OP_MOD: begin
                s1   = wr * wr + wi * wi;
                sq   = s1[63:0];
                root = '0;
                bitv = 64'd1 << 62;
                while (bitv > sq) bitv = bitv >> 2;
                while (bitv != 0) begin
                    if (sq >= root + bitv) begin
                        sq   = sq - (root + bitv);
                        root = (root >> 1) + bitv;
                    end else begin
                        root = root >> 1;
                    end
                    bitv = bitv >> 2;
                end
                r.re = clip_word(t_wide'({1'b0, root}), sat);
            end
            OP_ARG: begin
                if (ar == 0 && ai == 0) begin
                    r.err = 1'b1;
                end else begin
                    cx = ar;
                    cy = ai;
                    cz = 0;
                    if (cx == 0) begin
                        cz = (cy > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
                    end else if (cy == 0) begin
                        cz = (cx > 0) ? 0 : longint'(PI_Q30);
                    end else begin
                        if (cx < 0) begin
                            cz = (cy > 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
                            cx = -cx;
                            cy = -cy;
                        end
                        for (int i = 0; i < CORDIC_STEPS; i++) begin
                            dx = cy >>> i;
                            dy = cx >>> i;
                            if (cy > 0) begin
                                cx = cx + dx;
                                cy = cy - dy;
                                cz = cz + longint'(atan_q30(5'(i)));
                            end else begin
                                cx = cx - dx;
                                cy = cy + dy;
                                cz = cz - longint'(atan_q30(5'(i)));
                            end
                        end
                    end
                    r.re = clip_word(t_wide'(cz >>> (30 - FRAC_BITS)), sat);
                end
            end
            default: begin
                r.eq = (ar == br) && (ai == bi);
            end
        endcase
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            4: return 32'($signed($urandom_range(0, 2 * 256)) - 256);
            5: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        int gap;
        gap = send_idle ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19)) : 0;
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type = op;
        req_ch.a_re     = ar;
        req_ch.a_im     = ai;
        req_ch.b_re     = br;
        req_ch.b_im     = bi;
        req_ch.valid    = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_rsp.push_back(cau_predict(op, ar, ai, br, bi));
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        t_op         op;
        logic [31:0] ar, ai, br, bi;
        for (int n = 0; n < count; n++) begin
            op = t_op'($urandom_range(0, 7));
            ar = rand_word();
            ai = rand_word();
            br = rand_word();
            bi = rand_word();
            if (op == OP_EQ && $urandom_range(0, 1)) begin
                br = ar;
                if ($urandom_range(0, 2) != 0) bi = ai;
            end
            if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(op, ar, ai, br, bi);
        end
        req_ch.valid = 1'b0;
    endtask

    task automatic test_directed();
        send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_item(OP_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
        send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_item(OP_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00030000);
        send_item(OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_item(OP_MUL, 32'h00018000, 32'hfffe0000, 32'h00020000, 32'h00010000);
        send_item(OP_MUL, 32'hffffffff, 32'h00000001, 32'h00000001, 32'h00000001);
        send_item(OP_DIV, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
        send_item(OP_DIV, 32'h00030000, 32'h00020000, 32'h00010000, 32'hffff0000);
        send_item(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h00000000);
        send_item(OP_DIV, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_item(OP_CONJ, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        send_item(OP_CONJ, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0);
        send_item(OP_MOD, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        send_item(OP_MOD, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
        send_item(OP_ARG, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_ARG, 32'h0, 32'h00010000, 32'h0, 32'h0);
        send_item(OP_ARG, 32'h0, 32'h80000000, 32'h0, 32'h0);
        send_item(OP_ARG, 32'h7fffffff, 32'h0, 32'h0, 32'h0);
        send_item(OP_ARG, 32'h80000000, 32'h0, 32'h0, 32'h0);
        send_item(OP_ARG, 32'hffff0000, 32'hffff0000, 32'h0, 32'h0);
        send_item(OP_EQ, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000000);
        send_item(OP_EQ, 32'h12345678, 32'h80000000, 32'h12345678, 32'h80000001);
        req_ch.valid = 1'b0;
    endtask

    task automatic test_random_flow();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_random(100);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_random(200);
        send_idle = 1'b1;
        recv_idle = 1'b0;
        send_random(50);
    endtask

    // sink holds off while items keep coming, so the pipe fills and stalls its input
    task automatic test_backpressure();
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_cnt  = 300;
        send_random(100);
    endtask

    always @(negedge i_clk) begin
        if (took_rsp) begin
            took_rsp = 1'b0;
            wait_cnt = (recv_idle && $urandom_range(0, 1)) ? $urandom_range(0, 19) : 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt     = hold_cnt - 1;
            rsp_ch.ready = 1'b0;
        end else if (wait_cnt > 0) begin
            wait_cnt     = wait_cnt - 1;
            rsp_ch.ready = 1'b0;
        end else begin
            rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp act_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            took_rsp = 1'b1;
            act_r = '{re: rsp_ch.r_re, im: rsp_ch.r_im, err: rsp_ch.error,
                      eq: rsp_ch.equal, sat: rsp_ch.saturated};
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected item, actual %p", $time, act_r);
                fail_cnt++;
            end else begin
                exp_r = expected_rsp.pop_front();
                if (act_r.re !== exp_r.re) begin
                    $display("%0t: r_re expected %h actual %h", $time, exp_r.re, act_r.re);
                    fail_cnt++;
                end
                if (act_r.im !== exp_r.im) begin
                    $display("%0t: r_im expected %h actual %h", $time, exp_r.im, act_r.im);
                    fail_cnt++;
                end
                if (act_r.err !== exp_r.err) begin
                    $display("%0t: error expected %b actual %b", $time, exp_r.err, act_r.err);
                    fail_cnt++;
                end
                if (act_r.eq !== exp_r.eq) begin
                    $display("%0t: equal expected %b actual %b", $time, exp_r.eq, act_r.eq);
                    fail_cnt++;
                end
                if (act_r.sat !== exp_r.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
                             act_r.sat);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.a_re     = '0;
        req_ch.a_im     = '0;
        req_ch.b_re     = '0;
        req_ch.b_im     = '0;
        rsp_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_flow();
        test_backpressure();
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* complex_arithmetic_unit.f */
+incdir+src
src/cau_pkg.sv
src/cau_if.sv
src/cau_front.sv
src/cau_cell.sv
src/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_tb.sv
